[rtl/mfd_pkg.sv]
// Shared constants, types and the sine table builder for the modulated delay line.
// No dependencies; every other file imports this package.
package mfd_pkg;

  // Default sizes for the top-level parameters
  localparam int BUFFER_SIZE_DEF      = 4096;
  localparam int CHANNEL_COUNT_DEF    = 2;
  localparam int SINE_TABLE_DEPTH_DEF = 256;

  // Field widths
  localparam int SAMPLE_W   = 24;
  localparam int DELAY_W    = 20;
  localparam int DEPTH_W    = 16;
  localparam int PHASE_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Quarter turn in Q30 radians
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY_LENGTH    = 2'd0,
    CFG_MOD_DEPTH       = 2'd1,
    CFG_PHASE_INCREMENT = 2'd2
  } cfg_idx_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INDEX,
    ST_SINE,
    ST_SCALE,
    ST_POS,
    ST_ADDR,
    ST_READ1,
    ST_READ2,
    ST_INTERP,
    ST_ROUND,
    ST_DONE
  } mfd_state_t;

  // Sine of a Q30 angle in Q1.15, Taylor series to degree 13, rounded half up.
  // Evaluated only at elaboration to fill the quarter-wave table.
  function automatic logic [15:0] sine_q15(input logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + $signed(term);
    if (sum < 0) begin
      sum = '0;
    end
    return 16'((sum + 64'sd16384) >>> 15);
  endfunction

endpackage

[rtl/mfd_if.sv]
// Valid/ready stream interfaces for the input samples and the delayed results.
// Depends on mfd_pkg for the sample width.
interface mfd_in_if
  import mfd_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic                       channel;

  modport source (output valid, output sample_in, output channel, input ready);
  modport sink   (input valid, input sample_in, input channel, output ready);
endinterface

interface mfd_out_if
  import mfd_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

[rtl/modulated_fractional_delay_top.sv]
// Modulated fractional delay line: sequencer, shared multiplier, sample store.
// Depends on mfd_pkg and the stream interfaces in mfd_if.sv.
//
//   port      | direction | transfer when        | carries
//   ----------+-----------+----------------------+------------------------------
//   in_ch     | sink      | valid && ready       | sample_in, channel
//   out_ch    | source    | valid && ready       | sample_out
//   cfg_*     | write     | cfg_we high          | cfg_index, cfg_data
//
// A delayed item steps through the states INDEX, SINE, SCALE, POS, ADDR, READ1,
// READ2, INTERP, ROUND and DONE; a bypassed item goes from IDLE straight to DONE.
// Input is taken only in IDLE. The steps are set by the one multiplier used three
// times (table index, LFO scale, interpolation) and the read port read twice.
// Reset clears pointers, phases, wrap marks and control registers, not the store;
// never-written slots read as zero through a per-channel wrap mark.
// A result waits in the output register; the sequencer holds in its last state
// only when that register is still full and not taken.
module modulated_fractional_delay_top
  import mfd_pkg::*;
#(
  parameter int BUFFER_SIZE      = BUFFER_SIZE_DEF,
  parameter int CHANNEL_COUNT    = CHANNEL_COUNT_DEF,
  parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  mfd_in_if.sink                in_ch,
  mfd_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PTR_W   = $clog2(BUFFER_SIZE);
  localparam int CH_W    = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int POS_W   = 40;
  localparam int SINE_W  = 17;
  localparam int DIFF_W  = SAMPLE_W + 1;

  localparam logic [PTR_W:0]   BUF_LEN  = (PTR_W + 1)'(BUFFER_SIZE);
  localparam logic [PTR_W-1:0] BUF_LAST = PTR_W'(BUFFER_SIZE - 1);
  localparam logic [IDX_W-1:0] TAB_END  = IDX_W'(SINE_TABLE_DEPTH);
  localparam logic signed [POS_W-1:0]  POS_MAX =
    POS_W'(longint'(BUFFER_SIZE - 2) * 65536);
  localparam logic signed [PROD_W-1:0] SAT_HI  = PROD_W'(8388607);
  localparam logic signed [PROD_W-1:0] SAT_LO  = PROD_W'(-8388608);
  localparam logic [DELAY_W-1:0]       ONE_SAMPLE = DELAY_W'(256);

  // Quarter-wave sine table, constant
  logic [15:0] sine_rom [SINE_TABLE_DEPTH+1];
  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_sine
    assign sine_rom[k] = sine_q15((64'(k) * HALF_PI_Q30) / SINE_TABLE_DEPTH);
  end

  // Control and per-channel state
  mfd_state_t                state_r, state_nxt;
  logic [DELAY_W-1:0]        delay_r;
  logic [DEPTH_W-1:0]        depth_r;
  logic [PHASE_W-1:0]        incr_r;
  logic [PHASE_W-1:0]        phase_r   [CHANNEL_COUNT];
  logic [PHASE_W-1:0]        phase_nxt [CHANNEL_COUNT];
  logic [PTR_W-1:0]          wp_r      [CHANNEL_COUNT];
  logic [PTR_W-1:0]          wp_nxt    [CHANNEL_COUNT];
  logic [CHANNEL_COUNT-1:0]  wrapped_r, wrapped_nxt;
  logic                      out_valid_r, out_valid_nxt;

  // Datapath registers
  logic signed [SAMPLE_W-1:0] sample_r, sample_nxt;
  logic [CH_W-1:0]            ch_r, ch_nxt;
  logic signed [PROD_W-1:0]   mul_r;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [SINE_W-1:0]   sine_r, sine_nxt;
  logic [PTR_W-1:0]           d_r, d_nxt;
  logic [15:0]                frac_r, frac_nxt;
  logic [PTR_W-1:0]           i1_r, i1_nxt, i2_r, i2_nxt;
  logic                       v1_r, v1_nxt, v2_r, v2_nxt;
  logic signed [SAMPLE_W-1:0] s1_r, s1_nxt;
  logic signed [SAMPLE_W-1:0] result_r, result_nxt;
  logic signed [SAMPLE_W-1:0] out_data_r, out_data_nxt;

  // Sample store
  logic signed [SAMPLE_W-1:0] store_mem [CHANNEL_COUNT][BUFFER_SIZE];
  logic signed [SAMPLE_W-1:0] rd_data_r;
  logic [PTR_W-1:0]           rd_addr;
  logic                       mem_we;

  // Combinational helpers
  logic [PHASE_W-1:0]         cur_phase;
  logic [PTR_W-1:0]           cur_wp;
  logic                       cur_wrapped;
  logic [IDX_W-1:0]           tab_idx, tab_sel;
  logic [SINE_W-1:0]          sine_mag;
  logic signed [SINE_W-1:0]   sine_val;
  logic signed [PROD_W-1:0]   lfo_full;
  logic signed [POS_W-1:0]    pos, pos_c;
  logic [PTR_W-1:0]           i1_calc, i2_calc, wp_inc;
  logic signed [SAMPLE_W-1:0] s2;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [PROD_W-1:0]   acc, y;
  logic signed [SAMPLE_W-1:0] y_sat;
  logic [CH_W-1:0]            ch_in;

  assign cur_phase   = phase_r[ch_r];
  assign cur_wp      = wp_r[ch_r];
  assign cur_wrapped = wrapped_r[ch_r];
  assign ch_in       = (CHANNEL_COUNT > 1) ? CH_W'(in_ch.channel) : '0;

  // Table lookup: quadrant from the top phase bits, index from the product
  assign tab_idx  = mul_r[30 +: IDX_W];
  assign tab_sel  = cur_phase[30] ? (TAB_END - tab_idx) : tab_idx;
  assign sine_mag = {1'b0, sine_rom[tab_sel]};
  assign sine_val = cur_phase[31] ? -$signed(sine_mag) : $signed(sine_mag);

  // Delay position in Q.16 samples, clamped to the buffer
  assign lfo_full = (mul_r + $signed(PROD_W'(64))) >>> 7;
  assign pos      = POS_W'(lfo_full)
                  + $signed({{(POS_W - DELAY_W - 8){1'b0}}, delay_r, 8'h00});
  always_comb begin
    if (pos < 0) begin
      pos_c = '0;
    end else if (pos > POS_MAX) begin
      pos_c = POS_MAX;
    end else begin
      pos_c = pos;
    end
  end

  // Read slots behind the write pointer, wrapped into the buffer
  assign i1_calc = (cur_wp >= d_r) ? (cur_wp - d_r)
                                   : PTR_W'({1'b0, cur_wp} + BUF_LEN - {1'b0, d_r});
  assign i2_calc = (i1_calc == '0) ? BUF_LAST : (i1_calc - 1'b1);
  assign wp_inc  = (cur_wp == BUF_LAST) ? '0 : (cur_wp + 1'b1);

  // Interpolation: s1 + (s2 - s1) * f, rounded and saturated
  assign s2   = v2_r ? rd_data_r : '0;
  assign diff = $signed({s2[SAMPLE_W-1], s2}) - $signed({s1_r[SAMPLE_W-1], s1_r});
  assign acc  = $signed({{(PROD_W - SAMPLE_W - 16){s1_r[SAMPLE_W-1]}}, s1_r, 16'h0000})
              + mul_r + $signed(PROD_W'(32768));
  assign y    = acc >>> 16;
  always_comb begin
    if (y > SAT_HI) begin
      y_sat = SAT_HI[SAMPLE_W-1:0];
    end else if (y < SAT_LO) begin
      y_sat = SAT_LO[SAMPLE_W-1:0];
    end else begin
      y_sat = y[SAMPLE_W-1:0];
    end
  end

  assign rd_addr = (state_r == ST_READ1) ? i1_r : i2_r;

  // Sequencer: next state, shared multiplier operands, register updates
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    wp_nxt        = wp_r;
    wrapped_nxt   = wrapped_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    sample_nxt    = sample_r;
    ch_nxt        = ch_r;
    sine_nxt      = sine_r;
    d_nxt         = d_r;
    frac_nxt      = frac_r;
    i1_nxt        = i1_r;
    i2_nxt        = i2_r;
    v1_nxt        = v1_r;
    v2_nxt        = v2_r;
    s1_nxt        = s1_r;
    result_nxt    = result_r;
    mul_a         = '0;
    mul_b         = '0;
    mem_we        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          sample_nxt = in_ch.sample_in;
          ch_nxt     = ch_in;
          if (delay_r < ONE_SAMPLE) begin
            result_nxt = in_ch.sample_in;
            state_nxt  = ST_DONE;
          end else begin
            state_nxt  = ST_INDEX;
          end
        end
      end
      ST_INDEX: begin
        mul_a     = $signed({2'b00, cur_phase[29:0]});
        mul_b     = $signed(MUL_B_W'(SINE_TABLE_DEPTH));
        state_nxt = ST_SINE;
      end
      ST_SINE: begin
        sine_nxt  = sine_val;
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        mul_a     = MUL_A_W'(sine_r);
        mul_b     = $signed({2'b00, depth_r});
        state_nxt = ST_POS;
      end
      ST_POS: begin
        d_nxt     = pos_c[16 +: PTR_W];
        frac_nxt  = pos_c[15:0];
        state_nxt = ST_ADDR;
      end
      ST_ADDR: begin
        i1_nxt    = i1_calc;
        i2_nxt    = i2_calc;
        v1_nxt    = cur_wrapped || (i1_calc < cur_wp);
        v2_nxt    = cur_wrapped || (i2_calc < cur_wp);
        state_nxt = ST_READ1;
      end
      ST_READ1: begin
        state_nxt = ST_READ2;
      end
      ST_READ2: begin
        s1_nxt    = v1_r ? rd_data_r : '0;
        state_nxt = ST_INTERP;
      end
      ST_INTERP: begin
        mul_a     = MUL_A_W'(diff);
        mul_b     = $signed({2'b00, frac_r});
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        // Commit: store the new sample, advance pointer and phase
        result_nxt        = y_sat;
        mem_we            = 1'b1;
        wp_nxt[ch_r]      = wp_inc;
        phase_nxt[ch_r]   = cur_phase + incr_r;
        if (cur_wp == BUF_LAST) begin
          wrapped_nxt[ch_r] = 1'b1;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = result_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_data_r;

  // Control registers and configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      phase_r     <= '{default: '0};
      wp_r        <= '{default: '0};
      wrapped_r   <= '0;
      delay_r     <= '0;
      depth_r     <= '0;
      incr_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
      wp_r        <= wp_nxt;
      wrapped_r   <= wrapped_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_DELAY_LENGTH:    delay_r <= cfg_data[DELAY_W-1:0];
          CFG_MOD_DEPTH:       depth_r <= cfg_data[DEPTH_W-1:0];
          CFG_PHASE_INCREMENT: incr_r  <= cfg_data[PHASE_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers and the shared multiplier
  always_ff @(posedge clk) begin
    sample_r   <= sample_nxt;
    ch_r       <= ch_nxt;
    sine_r     <= sine_nxt;
    d_r        <= d_nxt;
    frac_r     <= frac_nxt;
    i1_r       <= i1_nxt;
    i2_r       <= i2_nxt;
    v1_r       <= v1_nxt;
    v2_r       <= v2_nxt;
    s1_r       <= s1_nxt;
    result_r   <= result_nxt;
    out_data_r <= out_data_nxt;
    mul_r      <= mul_a * mul_b;
  end

  // Sample store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[ch_r][cur_wp] <= sample_r;
    end
    rd_data_r <= store_mem[ch_r][rd_addr];
  end

endmodule

[rtl/mfd_checker.sv]
// Port-level checks for the modulated delay line, bound to the top level.
// Depends on mfd_pkg for the sample width.
module mfd_checker
  import mfd_pkg::*;
(
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [SAMPLE_W-1:0] out_sample
);

  // Hold a waiting result unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample))
    else $error("result dropped or changed while stalled");

  // Drop ready for the item in progress
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer taken while an item is in progress");

  // No result appears in the cycle right after a transfer
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result raised too early");

  // A new result only comes out of a busy period
  a_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result raised while input side idle");

endmodule

bind modulated_fractional_delay_top mfd_checker u_mfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_sample (out_ch.sample_out)
);
